### src/olra_pkg.sv
// Shared types and constants for the ordered list remove-and-advance core.
// No dependencies; imported by ordered_list_remove_and_advance_core.
package olra_pkg;

    localparam int ID_W            = 11;
    localparam int ID_LIMIT        = (1 << ID_W) - 1;  // largest id the fields can carry
    localparam int DEFAULT_MAX_IDS = 1024;
    localparam logic [ID_W-1:0] LEN_RESET = ID_W'(1);

    typedef enum logic [1:0] {
        FUNC_UNLINK  = 2'd0,
        FUNC_ADVANCE = 2'd1,
        FUNC_REBUILD = 2'd2,
        FUNC_QUERY   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        STAT_DONE  = 2'd0,
        STAT_FIRST = 2'd1,
        STAT_BADID = 2'd2
    } status_t;

    // one list table entry: membership flag plus both links
    typedef struct packed {
        logic            present;
        logic [ID_W-1:0] prev;
        logic [ID_W-1:0] next;
    } entry_t;

endpackage

### src/ordered_list_remove_and_advance_core.sv
// Top level of the ordered list remove-and-advance core: FSM plus link table memory.
// Depends on olra_pkg (types, codes, widths).
//
// Keeps ids 1..N in a doubly linked list behind a head sentinel (id 0). Each
// transfer on the s_ channel is one operation (unlink, advance one place,
// rebuild, query) and yields exactly one result transfer on the m_ channel.
// All links and membership flags live in one table memory, one entry per id,
// with a single read and a single write port and a registered read. A query,
// a rejected id or an advance of an id already first only checks the entry;
// unlink clears the item, then patches predecessor and successor; advance
// rewrites item, pre-predecessor, old predecessor, successor (both skip the
// successor when the id is last); rebuild sweeps entries 0..MIN(MAX_IDS, 2047)
// once. Items are taken only in idle. The list is empty after reset; a rebuild
// is needed before the table holds anything. The user must write list_length
// through cfg_wr_en/cfg_wr_data while the core is idle; it does not enforce this.
module ordered_list_remove_and_advance_core
    import olra_pkg::*;
#(
    parameter int unsigned MAX_IDS = DEFAULT_MAX_IDS
) (
    input  logic            aclk,
    input  logic            aresetn,

    input  logic            cfg_wr_en,
    input  logic [ID_W-1:0] cfg_wr_data,

    input  logic            s_valid,
    output logic            s_ready,
    input  logic [1:0]      s_func,
    input  logic [ID_W-1:0] s_item_id,

    output logic            m_valid,
    input  logic            m_ready,
    output logic [1:0]      m_status,
    output logic [ID_W-1:0] m_successor,
    output logic [ID_W-1:0] m_predecessor
);

    // ids above the field range can never be named, so the table stops there
    localparam int EFF_MAX = (MAX_IDS > ID_LIMIT) ? ID_LIMIT : int'(MAX_IDS);
    localparam int DEPTH   = EFF_MAX + 1;
    localparam int AW      = $clog2(DEPTH);

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_CHK   = 10'b0000000010,  // entry of item arrives, validate
        ST_U_P   = 10'b0000000100,  // unlink: patch predecessor
        ST_U_N   = 10'b0000001000,  // unlink: patch successor
        ST_A_P   = 10'b0000010000,  // advance: predecessor arrives, rewrite item
        ST_A_F   = 10'b0000100000,  // advance: patch pre-predecessor
        ST_A_WP  = 10'b0001000000,  // advance: rewrite old predecessor
        ST_A_N   = 10'b0010000000,  // advance: patch successor
        ST_BUILD = 10'b0100000000,  // rebuild sweep
        ST_DONE  = 10'b1000000000   // hand result to output register
    } state_t;

    function automatic logic [AW-1:0] to_addr(input logic [ID_W-1:0] x);
        return x[AW-1:0];
    endfunction

    // link table
    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    entry_t          mem_wdata;
    logic [AW-1:0]   mem_raddr;

    // control state
    state_t          state_reg, state_next;
    logic            built_reg, built_next;
    logic [ID_W-1:0] len_reg;
    logic [AW-1:0]   cnt_reg, cnt_next;
    logic            m_valid_reg, m_valid_next;

    // operation context (no reset needed)
    logic [1:0]      func_reg, func_next;
    logic [ID_W-1:0] id_reg, id_next;
    logic [ID_W-1:0] p_reg, p_next;
    logic [ID_W-1:0] n_reg, n_next;
    logic [ID_W-1:0] f_reg, f_next;

    // pending result and output register
    logic [1:0]      res_status_reg, res_status_next;
    logic [ID_W-1:0] res_succ_reg, res_succ_next;
    logic [ID_W-1:0] res_pred_reg, res_pred_next;
    logic [1:0]      m_status_reg, m_status_next;
    logic [ID_W-1:0] m_succ_reg, m_succ_next;
    logic [ID_W-1:0] m_pred_reg, m_pred_next;

    // helpers
    logic [ID_W-1:0] len_eff;
    logic [ID_W-1:0] sweep_id;
    logic            sweep_in_list;
    logic            s_in_range;
    logic            id_member;
    logic            s_fire;
    logic            out_free;

    assign s_ready       = (state_reg == ST_IDLE);
    assign s_fire        = s_valid && s_ready;
    assign out_free      = !m_valid_reg || m_ready;

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_successor   = m_succ_reg;
    assign m_predecessor = m_pred_reg;

    // rebuild length saturates at the table size
    assign len_eff       = (len_reg > ID_W'(EFF_MAX)) ? ID_W'(EFF_MAX) : len_reg;
    assign sweep_id      = ID_W'(cnt_reg);
    assign sweep_in_list = (sweep_id != '0) && (sweep_id <= len_eff);

    assign s_in_range    = (s_item_id <= ID_W'(EFF_MAX));
    // membership of id_reg, valid in ST_CHK while its entry sits in rd_data_reg
    assign id_member     = (id_reg != '0) && (id_reg <= ID_W'(EFF_MAX))
                           && built_reg && rd_data_reg.present;

    always_comb begin
        state_next      = state_reg;
        built_next      = built_reg;
        cnt_next        = cnt_reg;
        m_valid_next    = m_valid_reg;
        func_next       = func_reg;
        id_next         = id_reg;
        p_next          = p_reg;
        n_next          = n_reg;
        f_next          = f_reg;
        res_status_next = res_status_reg;
        res_succ_next   = res_succ_reg;
        res_pred_next   = res_pred_reg;
        m_status_next   = m_status_reg;
        m_succ_next     = m_succ_reg;
        m_pred_next     = m_pred_reg;

        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = rd_data_reg;
        mem_raddr       = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                // fetch the item's entry as it is accepted
                mem_raddr = s_in_range ? to_addr(s_item_id) : '0;
                if (s_fire) begin
                    func_next = s_func;
                    id_next   = s_item_id;
                    if (s_func == FUNC_REBUILD) begin
                        cnt_next   = '0;
                        state_next = ST_BUILD;
                    end else begin
                        state_next = ST_CHK;
                    end
                end
            end

            ST_CHK: begin
                p_next     = rd_data_reg.prev;
                n_next     = rd_data_reg.next;
                state_next = ST_DONE;
                if (func_reg == FUNC_QUERY) begin
                    if (id_reg == '0 || id_member) begin
                        res_status_next = STAT_DONE;
                        res_succ_next   = rd_data_reg.next;
                        res_pred_next   = rd_data_reg.prev;
                    end else begin
                        res_status_next = STAT_BADID;
                        res_succ_next   = '0;
                        res_pred_next   = '0;
                    end
                end else if (!id_member) begin
                    res_status_next = STAT_BADID;
                    res_succ_next   = '0;
                    res_pred_next   = '0;
                end else if (func_reg == FUNC_UNLINK) begin
                    mem_we     = 1'b1;
                    mem_waddr  = to_addr(id_reg);
                    mem_wdata  = '0;
                    mem_raddr  = to_addr(rd_data_reg.prev);
                    state_next = ST_U_P;
                end else if (rd_data_reg.prev == '0) begin
                    // already first
                    res_status_next = STAT_FIRST;
                    res_succ_next   = rd_data_reg.next;
                    res_pred_next   = '0;
                end else begin
                    mem_raddr  = to_addr(rd_data_reg.prev);
                    state_next = ST_A_P;
                end
            end

            ST_U_P: begin
                mem_we         = 1'b1;
                mem_waddr      = to_addr(p_reg);
                mem_wdata      = rd_data_reg;
                mem_wdata.next = n_reg;
                res_status_next = STAT_DONE;
                res_succ_next   = '0;
                res_pred_next   = '0;
                if (n_reg != '0) begin
                    mem_raddr  = to_addr(n_reg);
                    state_next = ST_U_N;
                end else begin
                    state_next = ST_DONE;
                end
            end

            ST_U_N: begin
                mem_we         = 1'b1;
                mem_waddr      = to_addr(n_reg);
                mem_wdata      = rd_data_reg;
                mem_wdata.prev = p_reg;
                state_next     = ST_DONE;
            end

            ST_A_P: begin
                // rd_data_reg holds the predecessor; its prev is f
                f_next            = rd_data_reg.prev;
                mem_we            = 1'b1;
                mem_waddr         = to_addr(id_reg);
                mem_wdata.present = 1'b1;
                mem_wdata.prev    = rd_data_reg.prev;
                mem_wdata.next    = p_reg;
                mem_raddr         = to_addr(rd_data_reg.prev);
                state_next        = ST_A_F;
            end

            ST_A_F: begin
                mem_we         = 1'b1;
                mem_waddr      = to_addr(f_reg);
                mem_wdata      = rd_data_reg;
                mem_wdata.next = id_reg;
                state_next     = ST_A_WP;
            end

            ST_A_WP: begin
                mem_we            = 1'b1;
                mem_waddr         = to_addr(p_reg);
                mem_wdata.present = 1'b1;
                mem_wdata.prev    = id_reg;
                mem_wdata.next    = n_reg;
                res_status_next   = STAT_DONE;
                res_succ_next     = p_reg;
                res_pred_next     = f_reg;
                if (n_reg != '0) begin
                    mem_raddr  = to_addr(n_reg);
                    state_next = ST_A_N;
                end else begin
                    state_next = ST_DONE;
                end
            end

            ST_A_N: begin
                mem_we         = 1'b1;
                mem_waddr      = to_addr(n_reg);
                mem_wdata      = rd_data_reg;
                mem_wdata.prev = p_reg;
                state_next     = ST_DONE;
            end

            ST_BUILD: begin
                // one entry per cycle; entries past the length are cleared
                mem_we            = 1'b1;
                mem_waddr         = cnt_reg;
                mem_wdata.present = sweep_in_list;
                mem_wdata.prev    = sweep_in_list ? (sweep_id - ID_W'(1)) : '0;
                if (sweep_id == '0) begin
                    mem_wdata.next = (len_eff != '0) ? ID_W'(1) : '0;
                end else if (sweep_in_list && sweep_id != len_eff) begin
                    mem_wdata.next = sweep_id + ID_W'(1);
                end else begin
                    mem_wdata.next = '0;
                end
                if (cnt_reg == AW'(EFF_MAX)) begin
                    built_next      = 1'b1;
                    res_status_next = STAT_DONE;
                    res_succ_next   = (len_eff != '0) ? ID_W'(1) : '0;
                    res_pred_next   = '0;
                    state_next      = ST_DONE;
                end else begin
                    cnt_next = cnt_reg + AW'(1);
                end
            end

            ST_DONE: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_succ_next   = res_succ_reg;
                    m_pred_next   = res_pred_reg;
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // table memory: one write, one registered read per cycle
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            built_reg   <= 1'b0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
            len_reg     <= LEN_RESET;
        end else begin
            state_reg   <= state_next;
            built_reg   <= built_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                len_reg <= cfg_wr_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        func_reg       <= func_next;
        id_reg         <= id_next;
        p_reg          <= p_next;
        n_reg          <= n_next;
        f_reg          <= f_next;
        res_status_reg <= res_status_next;
        res_succ_reg   <= res_succ_next;
        res_pred_reg   <= res_pred_next;
        m_status_reg   <= m_status_next;
        m_succ_reg     <= m_succ_next;
        m_pred_reg     <= m_pred_next;
    end

endmodule
